FILE: src/isr_pkg.sv
// Shared types and constants for the Ising ring Metropolis update block.
// Used by every module of the block; depends on nothing.
`default_nettype none

package isr_pkg;

	// Fixed field widths of the block ports.
	localparam int SITE_W     = 6;
	localparam int LEN_W      = 7;
	localparam int THR_W      = 16;
	localparam int SUM_W      = 8;
	localparam int SWEEP_W    = 16;
	localparam int CFG_IDX_W  = 2;
	localparam int CFG_DATA_W = 16;

	// Parameter defaults and limits.
	localparam int MAX_SPINS_DEF   = 64;
	localparam int DRAW_BITS_DEF   = 16;
	localparam int SITE_REACH      = 64;
	localparam int RING_LENGTH_RST = 64;

	// Local field value at which an uphill flip is tested against the threshold.
	localparam int H_UPHILL = 2;

	typedef enum logic [1:0] {
		CMD_FLIP  = 2'd0,
		CMD_LOAD  = 2'd1,
		CMD_SWEEP = 2'd2
	} cmd_t;

	typedef enum logic [CFG_IDX_W-1:0] {
		REG_RING_LENGTH      = 2'd0,
		REG_ACCEPT_THRESHOLD = 2'd1,
		REG_WARMUP_SWEEPS    = 2'd2
	} reg_idx_t;

	typedef enum logic [2:0] {
		ST_IDLE,
		ST_FLIP_A,
		ST_FLIP_B,
		ST_FLIP_C,
		ST_FLIP_W,
		ST_MEAS_RUN,
		ST_MEAS_WAIT,
		ST_MEAS_END
	} seq_state_t;

	// Write request into the spin store.
	typedef struct packed {
		logic              en;
		logic [SITE_W-1:0] addr;
		logic              data;
	} spin_wr_t;

	// Work handed from the command decoder to the sequencer.
	typedef struct packed {
		logic              flip;
		logic              meas;
		logic [SITE_W-1:0] site;
		logic              draw_lt;
	} seq_go_t;

	// Control of the shared accumulator.
	typedef struct packed {
		logic clr_corr;
		logic clr_mag;
		logic en;
		logic mag_en;
	} acc_ctrl_t;

endpackage

`default_nettype wire

FILE: src/isr_spin_mem.sv
// Spin store: one write port, two registered read ports, per-entry valid bits.
// An entry never written reads as spin up. Depends on isr_pkg.
`default_nettype none

module isr_spin_mem #(
	parameter int DEPTH  = isr_pkg::SITE_REACH,
	parameter int ADDR_W = $clog2(DEPTH)
) (
	input  wire logic             clk,
	input  wire logic             arst_n,
	input  wire isr_pkg::spin_wr_t wr,
	input  wire logic [ADDR_W-1:0] rd_addr_a,
	input  wire logic [ADDR_W-1:0] rd_addr_b,
	output logic                  rd_data_a,
	output logic                  rd_data_b
);
	import isr_pkg::*;

	logic             mem_q   [DEPTH];
	logic [DEPTH-1:0] valid_q;

	// Valid bits: cleared by reset, set on the first write of an entry.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_q <= '0;
		end else if (wr.en) begin
			valid_q[wr.addr[ADDR_W-1:0]] <= 1'b1;
		end
	end

	// Storage array and registered read ports.
	always_ff @(posedge clk) begin
		if (wr.en) begin
			mem_q[wr.addr[ADDR_W-1:0]] <= wr.data;
		end
		rd_data_a <= valid_q[rd_addr_a] ? mem_q[rd_addr_a] : 1'b1;
		rd_data_b <= valid_q[rd_addr_b] ? mem_q[rd_addr_b] : 1'b1;
	end

endmodule

`default_nettype wire

FILE: src/isr_acc.sv
// Shared accumulator: sums spin products for the local field and the
// correlations, and sums single spins for the magnetization. Depends on isr_pkg.
`default_nettype none

module isr_acc (
	input  wire logic                        clk,
	input  wire logic                        arst_n,
	input  wire isr_pkg::acc_ctrl_t           ctrl,
	input  wire logic                        spin_a,
	input  wire logic                        spin_b,
	output logic signed [isr_pkg::SUM_W-1:0] corr,
	output logic signed [isr_pkg::SUM_W-1:0] mag
);
	import isr_pkg::*;

	localparam logic signed [SUM_W-1:0] PLUS_ONE  = SUM_W'(1);
	localparam logic signed [SUM_W-1:0] MINUS_ONE = -SUM_W'(1);

	logic signed [SUM_W-1:0] corr_q;
	logic signed [SUM_W-1:0] mag_q;
	logic signed [SUM_W-1:0] prod_term;
	logic signed [SUM_W-1:0] spin_term;

	// Product of two spins is +1 when they agree, -1 otherwise.
	assign prod_term = (spin_a == spin_b) ? PLUS_ONE : MINUS_ONE;
	assign spin_term = spin_a ? PLUS_ONE : MINUS_ONE;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			corr_q <= '0;
			mag_q  <= '0;
		end else begin
			if (ctrl.clr_corr) begin
				corr_q <= '0;
			end else if (ctrl.en) begin
				corr_q <= corr_q + prod_term;
			end
			if (ctrl.clr_mag) begin
				mag_q <= '0;
			end else if (ctrl.mag_en) begin
				mag_q <= mag_q + spin_term;
			end
		end
	end

	assign corr = corr_q;
	assign mag  = mag_q;

endmodule

`default_nettype wire

FILE: src/isr_seq.sv
// Sequencer: walks the spin store for flip attempts and measurements,
// drives the shared accumulator and registers the results. Depends on isr_pkg.
`default_nettype none

module isr_seq #(
	parameter int ADDR_W = 6,
	parameter int CNT_W  = 7
) (
	input  wire logic                         clk,
	input  wire logic                         arst_n,
	input  wire isr_pkg::seq_go_t              go,
	input  wire logic [CNT_W-1:0]             eff_len,
	input  wire logic                         rd_data_a,
	input  wire logic signed [isr_pkg::SUM_W-1:0] corr,
	input  wire logic signed [isr_pkg::SUM_W-1:0] mag,
	output logic [ADDR_W-1:0]                 rd_addr_a,
	output logic [ADDR_W-1:0]                 rd_addr_b,
	output isr_pkg::spin_wr_t                  wr,
	output isr_pkg::acc_ctrl_t                 acc,
	output logic                              busy,
	output logic                              result_strobe,
	output logic [isr_pkg::SITE_W-1:0]        distance,
	output logic signed [isr_pkg::SUM_W-1:0]  correlation_sum,
	output logic signed [isr_pkg::SUM_W-1:0]  magnetization_sum,
	output logic signed [isr_pkg::SUM_W-1:0]  energy_sum,
	output logic                              last
);
	import isr_pkg::*;

	seq_state_t state_q, state_d;

	logic [ADDR_W-1:0] site_q;
	logic              draw_lt_q;
	logic [ADDR_W-1:0] idx_q;
	logic [ADDR_W-1:0] bptr_q;
	logic [ADDR_W-1:0] d_q;
	logic              pre_q;
	logic              vld_s1;
	logic              issue;
	logic              emit;
	logic              result_strobe_q;
	logic signed [SUM_W-1:0] energy_q;
	logic [SITE_W-1:0]       distance_q;
	logic signed [SUM_W-1:0] corr_out_q;
	logic signed [SUM_W-1:0] mag_out_q;
	logic signed [SUM_W-1:0] energy_out_q;
	logic                    last_q;

	logic [ADDR_W-1:0] nm1;
	logic [ADDR_W-1:0] left_addr;
	logic [ADDR_W-1:0] right_addr;
	logic [ADDR_W-1:0] bptr_next;
	logic [ADDR_W-1:0] d_next;

	// Ring neighbors and the wrapping pointer step.
	assign nm1        = ADDR_W'(eff_len - CNT_W'(1));
	assign left_addr  = (site_q == '0) ? nm1 : ADDR_W'(site_q - ADDR_W'(1));
	assign right_addr = (site_q == nm1) ? '0 : ADDR_W'(site_q + ADDR_W'(1));
	assign bptr_next  = (bptr_q == nm1) ? '0 : ADDR_W'(bptr_q + ADDR_W'(1));
	assign d_next     = ADDR_W'(d_q + ADDR_W'(1));

	// State register.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= ST_IDLE;
		end else begin
			state_q <= state_d;
		end
	end

	// Next state, read addresses, accumulator control and write request.
	always_comb begin
		state_d      = state_q;
		rd_addr_a    = site_q;
		rd_addr_b    = bptr_q;
		wr           = '0;
		acc          = '0;
		issue        = 1'b0;
		emit         = 1'b0;
		unique case (state_q)
			ST_IDLE: begin
				if (go.flip) begin
					acc.clr_corr = 1'b1;
					state_d      = ST_FLIP_A;
				end else if (go.meas) begin
					acc.clr_corr = 1'b1;
					acc.clr_mag  = 1'b1;
					state_d      = ST_MEAS_RUN;
				end
			end
			ST_FLIP_A: begin
				rd_addr_b = left_addr;
				issue     = 1'b1;
				state_d   = ST_FLIP_B;
			end
			ST_FLIP_B: begin
				rd_addr_b = right_addr;
				issue     = 1'b1;
				state_d   = ST_FLIP_C;
			end
			ST_FLIP_C: begin
				state_d = ST_FLIP_W;
			end
			ST_FLIP_W: begin
				// Downhill or level moves always flip; uphill ones take the draw.
				wr.en   = (corr != SUM_W'(H_UPHILL)) || draw_lt_q;
				wr.addr = SITE_W'(site_q);
				wr.data = ~rd_data_a;
				state_d = ST_IDLE;
			end
			ST_MEAS_RUN: begin
				rd_addr_a = idx_q;
				issue     = 1'b1;
				if (idx_q == nm1) begin
					state_d = ST_MEAS_WAIT;
				end
			end
			ST_MEAS_WAIT: begin
				state_d = ST_MEAS_END;
			end
			ST_MEAS_END: begin
				acc.clr_corr = 1'b1;
				if (pre_q) begin
					state_d = ST_MEAS_RUN;
				end else begin
					emit = 1'b1;
					if (d_q == nm1) begin
						state_d = ST_IDLE;
					end else begin
						state_d = ST_MEAS_RUN;
					end
				end
			end
			default: begin
				state_d = ST_IDLE;
			end
		endcase
		acc.en     = vld_s1;
		acc.mag_en = vld_s1 && pre_q;
	end

	// Pass counters and read pipeline flag.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			idx_q           <= '0;
			bptr_q          <= '0;
			d_q             <= '0;
			pre_q           <= 1'b0;
			vld_s1          <= 1'b0;
			result_strobe_q <= 1'b0;
		end else begin
			vld_s1          <= issue;
			result_strobe_q <= emit;
			if (state_q == ST_IDLE && !go.flip && go.meas) begin
				// The first pass at distance one yields energy and magnetization.
				pre_q  <= 1'b1;
				idx_q  <= '0;
				d_q    <= '0;
				bptr_q <= (nm1 == '0) ? '0 : ADDR_W'(1);
			end else if (state_q == ST_MEAS_RUN) begin
				idx_q  <= ADDR_W'(idx_q + ADDR_W'(1));
				bptr_q <= bptr_next;
			end else if (state_q == ST_MEAS_END) begin
				pre_q <= 1'b0;
				idx_q <= '0;
				if (pre_q) begin
					d_q    <= '0;
					bptr_q <= '0;
				end else begin
					d_q    <= d_next;
					bptr_q <= d_next;
				end
			end
		end
	end

	// Latched request fields, energy and the result registers.
	always_ff @(posedge clk) begin
		if (state_q == ST_IDLE && go.flip) begin
			site_q    <= go.site[ADDR_W-1:0];
			draw_lt_q <= go.draw_lt;
		end
		if (state_q == ST_MEAS_END && pre_q) begin
			energy_q <= -corr;
		end
		if (emit) begin
			distance_q   <= SITE_W'(d_q);
			corr_out_q   <= corr;
			mag_out_q    <= mag;
			energy_out_q <= energy_q;
			last_q       <= (d_q == nm1);
		end
	end

	assign busy              = (state_q != ST_IDLE);
	assign result_strobe     = result_strobe_q;
	assign distance          = distance_q;
	assign correlation_sum   = corr_out_q;
	assign magnetization_sum = mag_out_q;
	assign energy_sum        = energy_out_q;
	assign last              = last_q;

endmodule

`default_nettype wire

FILE: src/ising_ring_metropolis_update.sv
// Top level of the Ising ring Metropolis update: configuration registers,
// command decode, sweep counter. Depends on isr_pkg, isr_spin_mem, isr_acc, isr_seq.
//
//   Channel  | Handshake                | Payload
//   ---------+--------------------------+------------------------------------------
//   request  | start, busy              | command, site, accept_draw, spin_up
//   result   | result_strobe            | distance, correlation_sum,
//            |                          | magnetization_sum, energy_sum, last
//   config   | cfg_valid, cfg_ready     | cfg_index, cfg_data
//
// A load, an ignored command or a sweep end within warm-up completes at its
// accepting edge. A flip attempt keeps busy high after acceptance through states
// FLIP_A, FLIP_B, FLIP_C and FLIP_W (reads of the site and both neighbors via the
// two-port spin store, then the decision and write). In a measuring sweep end every
// pass reads one pair of spins per cycle into the single accumulator, and one
// result leaves per distance. Reset is immediate: valid bits make the store read
// all spins up. Results cannot be stalled; each is shown for exactly one cycle.
`default_nettype none

module ising_ring_metropolis_update #(
	parameter int MAX_SPINS = isr_pkg::MAX_SPINS_DEF,
	parameter int DRAW_BITS = isr_pkg::DRAW_BITS_DEF
) (
	input  wire logic                              clk,
	input  wire logic                              arst_n,
	input  wire logic                              start,
	output logic                                   busy,
	input  wire logic [1:0]                        command,
	input  wire logic [isr_pkg::SITE_W-1:0]        site,
	input  wire logic [DRAW_BITS-1:0]              accept_draw,
	input  wire logic                              spin_up,
	output logic                                   result_strobe,
	output logic [isr_pkg::SITE_W-1:0]             distance,
	output logic signed [isr_pkg::SUM_W-1:0]       correlation_sum,
	output logic signed [isr_pkg::SUM_W-1:0]       magnetization_sum,
	output logic signed [isr_pkg::SUM_W-1:0]       energy_sum,
	output logic                                   last,
	input  wire logic                              cfg_valid,
	output logic                                   cfg_ready,
	input  wire logic [isr_pkg::CFG_IDX_W-1:0]     cfg_index,
	input  wire logic [isr_pkg::CFG_DATA_W-1:0]    cfg_data
);
	import isr_pkg::*;

	localparam int STORE_DEPTH = (MAX_SPINS < SITE_REACH) ? MAX_SPINS : SITE_REACH;
	localparam int ADDR_W      = $clog2(STORE_DEPTH);
	localparam int CNT_W       = $clog2(STORE_DEPTH + 1);
	localparam int CMP_W       = (DRAW_BITS > THR_W) ? DRAW_BITS : THR_W;

	logic [LEN_W-1:0]   ring_length_q;
	logic [THR_W-1:0]   accept_threshold_q;
	logic [SWEEP_W-1:0] warmup_q;
	logic [SWEEP_W-1:0] sweep_q;
	logic [SWEEP_W-1:0] sweep_next;
	logic [CNT_W-1:0]   eff_len;
	logic               accept;
	logic               site_ok;
	logic               draw_lt;
	logic               sweep_en;
	seq_go_t            go;
	spin_wr_t           load_wr;
	spin_wr_t           seq_wr;
	spin_wr_t           mem_wr;
	acc_ctrl_t          acc_ctrl;
	logic [ADDR_W-1:0]  rd_addr_a;
	logic [ADDR_W-1:0]  rd_addr_b;
	logic               rd_data_a;
	logic               rd_data_b;
	logic signed [SUM_W-1:0] corr;
	logic signed [SUM_W-1:0] mag;
	logic               seq_busy;

	// Configuration registers; the port never stalls.
	assign cfg_ready = 1'b1;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			ring_length_q      <= LEN_W'(RING_LENGTH_RST);
			accept_threshold_q <= '0;
			warmup_q           <= '0;
		end else if (cfg_valid && cfg_ready) begin
			unique case (reg_idx_t'(cfg_index))
				REG_RING_LENGTH:      ring_length_q      <= cfg_data[LEN_W-1:0];
				REG_ACCEPT_THRESHOLD: accept_threshold_q <= cfg_data[THR_W-1:0];
				REG_WARMUP_SWEEPS:    warmup_q           <= cfg_data[SWEEP_W-1:0];
				default: ;
			endcase
		end
	end

	// Effective ring length, clamped to one through the store depth.
	always_comb begin
		if (ring_length_q == '0) begin
			eff_len = CNT_W'(1);
		end else if (ring_length_q > LEN_W'(STORE_DEPTH)) begin
			eff_len = CNT_W'(STORE_DEPTH);
		end else begin
			eff_len = CNT_W'(ring_length_q);
		end
	end

	assign accept     = start && !busy;
	assign site_ok    = LEN_W'(site) < LEN_W'(eff_len);
	assign draw_lt    = CMP_W'(accept_draw) < CMP_W'(accept_threshold_q);
	assign sweep_next = (sweep_q == '1) ? sweep_q : SWEEP_W'(sweep_q + SWEEP_W'(1));

	// Command decode.
	always_comb begin
		go       = '0;
		load_wr  = '0;
		sweep_en = 1'b0;
		go.site    = site;
		go.draw_lt = draw_lt;
		load_wr.addr = site;
		load_wr.data = spin_up;
		if (accept) begin
			unique case (cmd_t'(command))
				CMD_FLIP:  go.flip = site_ok;
				CMD_LOAD:  load_wr.en = site_ok;
				CMD_SWEEP: begin
					sweep_en = 1'b1;
					go.meas  = sweep_next > warmup_q;
				end
				default: ;
			endcase
		end
	end

	// Saturating sweep counter.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			sweep_q <= '0;
		end else if (sweep_en) begin
			sweep_q <= sweep_next;
		end
	end

	// Loads and flips never coincide; the sequencer write wins anyway.
	assign mem_wr = seq_wr.en ? seq_wr : load_wr;

	isr_spin_mem #(
		.DEPTH  (STORE_DEPTH),
		.ADDR_W (ADDR_W)
	) u_mem (
		.clk       (clk),
		.arst_n    (arst_n),
		.wr        (mem_wr),
		.rd_addr_a (rd_addr_a),
		.rd_addr_b (rd_addr_b),
		.rd_data_a (rd_data_a),
		.rd_data_b (rd_data_b)
	);

	isr_acc u_acc (
		.clk    (clk),
		.arst_n (arst_n),
		.ctrl   (acc_ctrl),
		.spin_a (rd_data_a),
		.spin_b (rd_data_b),
		.corr   (corr),
		.mag    (mag)
	);

	isr_seq #(
		.ADDR_W (ADDR_W),
		.CNT_W  (CNT_W)
	) u_seq (
		.clk               (clk),
		.arst_n            (arst_n),
		.go                (go),
		.eff_len           (eff_len),
		.rd_data_a         (rd_data_a),
		.corr              (corr),
		.mag               (mag),
		.rd_addr_a         (rd_addr_a),
		.rd_addr_b         (rd_addr_b),
		.wr                (seq_wr),
		.acc               (acc_ctrl),
		.busy              (seq_busy),
		.result_strobe     (result_strobe),
		.distance          (distance),
		.correlation_sum   (correlation_sum),
		.magnetization_sum (magnetization_sum),
		.energy_sum        (energy_sum),
		.last              (last)
	);

	assign busy = seq_busy;

endmodule

`default_nettype wire

FILE: src/isr_checker.sv
// Port-level checks for the Ising ring Metropolis update, bound to the top level.
// Depends on isr_pkg and ising_ring_metropolis_update.
`default_nettype none

module isr_checker (
	input wire logic                               clk,
	input wire logic                               arst_n,
	input wire logic                               busy,
	input wire logic                               result_strobe,
	input wire logic                               last,
	input wire logic [isr_pkg::SITE_W-1:0]         distance,
	input wire logic signed [isr_pkg::SUM_W-1:0]   correlation_sum
);

	// Results of one measurement are never shown back to back.
	a_result_spacing: assert property (@(posedge clk) disable iff (!arst_n)
		result_strobe |=> !result_strobe)
		else $error("two results in consecutive cycles");

	// A result that is not the last one leaves while the measurement goes on.
	a_busy_mid_measure: assert property (@(posedge clk) disable iff (!arst_n)
		(result_strobe && !last) |-> busy)
		else $error("block idle before the last result");

	// Self-correlation at distance zero equals the ring length, so it is positive.
	a_zero_distance: assert property (@(posedge clk) disable iff (!arst_n)
		(result_strobe && distance == '0) |->
			(!correlation_sum[isr_pkg::SUM_W-1] && correlation_sum != '0))
		else $error("distance zero correlation not positive");

	// The last result closes the measurement.
	a_last_ends: assert property (@(posedge clk) disable iff (!arst_n)
		(result_strobe && last) |-> !busy)
		else $error("block still busy after the last result");

endmodule

bind ising_ring_metropolis_update isr_checker u_isr_checker (.*);

`default_nettype wire
